// File: sv/dvbf_pkg.sv
// Shared types and constants of the DV black frame byte generator.
package dvbf_pkg;

  // Frame geometry
  localparam int unsigned MAX_SEQUENCES  = 12;
  localparam int unsigned SEQ_W          = 4;
  localparam int unsigned BLK_W          = 8;
  localparam int unsigned POS_W          = 7;
  localparam logic [BLK_W-1:0] LAST_BLK  = 8'd149;
  localparam logic [POS_W-1:0] LAST_POS  = 7'd79;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W     = 1;
  localparam int unsigned CFG_DATA_W     = 4;
  localparam logic [CFG_ADDR_W-1:0] CFG_PAL_MODE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SEQ_CNT  = 1'b1;

  // Block ID type codes
  localparam logic [7:0] ID_HEADER  = 8'h1f;
  localparam logic [7:0] ID_SUBCODE = 8'h3f;
  localparam logic [7:0] ID_VAUX    = 8'h56;
  localparam logic [7:0] ID_AUDIO   = 8'h76;
  localparam logic [7:0] ID_VIDEO   = 8'h96;

  // Frame position of one emitted byte
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [BLK_W-1:0] blk;
    logic [POS_W-1:0] pos;
    logic             last;
  } pos_t;

endpackage

// File: sv/dvbf_pos.sv
// Input stage: frame position counters and the registered position of each item.
module dvbf_pos import dvbf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             restart_i,
  input  logic [SEQ_W-1:0] seq_cnt_i,   // effective sequence count, 1..MAX_SEQUENCES
  input  logic             adv_i,       // next stage takes the held position
  output logic             valid_o,
  output pos_t             pos_o
);

  logic [SEQ_W-1:0] seq_q, seq_d;
  logic [BLK_W-1:0] blk_q, blk_d;
  logic [POS_W-1:0] byte_q, byte_d;
  logic             valid_q;
  pos_t             pos_q, cur;
  logic             accept;

  assign in_ready_o = !valid_q || adv_i;
  assign accept     = in_valid_i && in_ready_o;

  // Current position and the one after it
  always_comb begin
    cur.seq  = restart_i ? '0 : seq_q;
    cur.blk  = restart_i ? '0 : blk_q;
    cur.pos  = restart_i ? '0 : byte_q;
    cur.last = (cur.blk == LAST_BLK) && (cur.pos == LAST_POS) &&
               (({1'b0, cur.seq} + 5'd1) >= {1'b0, seq_cnt_i});
    seq_d  = cur.seq;
    blk_d  = cur.blk;
    byte_d = cur.pos + 7'd1;
    if (cur.pos == LAST_POS) begin
      byte_d = '0;
      blk_d  = cur.blk + 8'd1;
      if (cur.blk == LAST_BLK) begin
        blk_d = '0;
        seq_d = cur.last ? '0 : cur.seq + 4'd1;
      end
    end
  end

  // Counters move on every accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= '0;
      blk_q   <= '0;
      byte_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        seq_q  <= seq_d;
        blk_q  <= blk_d;
        byte_q <= byte_d;
      end
      if (in_ready_o) valid_q <= in_valid_i;
    end
  end

  // Position register, payload only
  always_ff @(posedge clk_i) begin
    if (accept) pos_q <= cur;
  end

  assign valid_o = valid_q;
  assign pos_o   = pos_q;

endmodule

// File: sv/dvbf_enc.sv
// Output stage: frame byte for a position, and the result register.
module dvbf_enc import dvbf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  pos_t        pos_i,
  input  logic        pal_i,
  output logic        adv_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  // Byte value at a frame position
  function automatic logic [7:0] frame_byte(input logic [SEQ_W-1:0] seq,
                                            input logic [BLK_W-1:0] blk,
                                            input logic [POS_W-1:0] pos,
                                            input logic pal);
    logic [POS_W-1:0] p;
    logic [BLK_W-1:0] b7;
    logic [7:0]       res;
    b7  = blk - 8'd7;
    res = 8'hff;
    p   = '0;
    if (pos == 7'd1) begin
      res = {seq, 4'h7};
    end else if (blk == 8'd0) begin
      // header
      case (pos)
        7'd0:    res = ID_HEADER;
        7'd2:    res = 8'h00;
        7'd3:    res = pal ? 8'hbf : 8'h3f;
        7'd4:    res = 8'hf8 | {7'd0, ~pal};
        7'd5:    res = 8'h78 | {7'd0, ~pal};
        default: res = 8'hff;
      endcase
    end else if (blk < 8'd3) begin
      // subcode
      if (pos == 7'd0) res = ID_SUBCODE;
      else if (pos == 7'd2) res = blk - 8'd1;
    end else if (blk < 8'd6) begin
      // VAUX, packs repeated at payload offset 45
      if (pos == 7'd0) res = ID_VAUX;
      else if (pos == 7'd2) res = blk - 8'd3;
      else begin
        p = pos - 7'd3;
        if (p >= 7'd45 && p < 7'd55) p = p - 7'd45;
        case (p)
          7'd0:    res = 8'h60;
          7'd3:    res = 8'hc0 | {2'b00, pal, 5'd0};
          7'd5:    res = 8'h61;
          7'd6:    res = 8'h3f;
          7'd7:    res = 8'hc8;
          7'd8:    res = 8'hfc;
          default: res = 8'hff;
        endcase
      end
    end else if (blk[3:0] == 4'd6) begin
      // silent audio
      if (pos == 7'd0) res = ID_AUDIO;
      else if (pos == 7'd2) res = {4'd0, blk[7:4]};
      else res = (pos < 7'd8) ? 8'hff : 8'h00;
    end else begin
      // black video macroblock
      if (pos == 7'd0) res = ID_VIDEO;
      else if (pos == 7'd2) res = b7 - {4'd0, b7[7:4]};
      else if (pos == 7'd3) res = 8'h0f;
      else if (pos < 7'd60) begin
        p = pos - 7'd4;
        if (p >= 7'd42) p = p - 7'd42;
        else if (p >= 7'd28) p = p - 7'd28;
        else if (p >= 7'd14) p = p - 7'd14;
        res = (p == 7'd0) ? 8'h90 : ((p == 7'd1) ? 8'h06 : 8'h00);
      end else begin
        p = pos - 7'd60;
        if (p >= 7'd10) p = p - 7'd10;
        res = (p == 7'd1) ? 8'h16 : 8'h00;
      end
    end
    return res;
  endfunction

  logic        valid_q;
  logic [31:0] data_q, data_d;
  logic        last_q;

  assign adv_o = !valid_q || m_axis_tready_i;

  // Pack result fields, highest first
  assign data_d = {5'd0, pos_i.pos, pos_i.blk, pos_i.seq,
                   frame_byte(pos_i.seq, pos_i.blk, pos_i.pos, pal_i)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= valid_i;
    end
  end

  // Result register, payload only
  always_ff @(posedge clk_i) begin
    if (adv_o && valid_i) begin
      data_q <= data_d;
      last_q <= pos_i.last;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tlast_o  = last_q;

endmodule

// File: sv/dv_black_frame_byte_generator_top.sv
// Top level of the DV black frame byte generator.
// An item goes through the position register, then the result register.
// Throughput: one item per cycle; the position register and the result
// register each move whenever the stage after them is free.
// Reset: counters go to sequence 0, block 0, byte 0; pal_mode resets to 1,
// sequence_count to 12; no item is held after reset.
module dv_black_frame_byte_generator_top import dvbf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [7:0]            s_axis_tdata_i,   // [0] restart, [7:1] zero
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [7:0] data_byte, [11:8] sequence_number, [19:12] block_number,
  // [26:20] byte_offset, [31:27] zero
  output logic [31:0]           m_axis_tdata_o,
  output logic                  m_axis_tlast_o    // last_in_frame
);

  logic             pal_q;
  logic [SEQ_W-1:0] seq_cnt_q;
  logic [SEQ_W-1:0] eff_cnt;
  logic             adv;
  logic             pos_valid;
  pos_t             pos;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_q     <= 1'b1;
      seq_cnt_q <= 4'd12;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_PAL_MODE: pal_q     <= cfg_wdata_i[0];
        CFG_SEQ_CNT:  seq_cnt_q <= cfg_wdata_i[SEQ_W-1:0];
        default:      ;
      endcase
    end
  end

  // Sequence count clamped to 1..MAX_SEQUENCES
  always_comb begin
    eff_cnt = seq_cnt_q;
    if (seq_cnt_q == '0) eff_cnt = 4'd1;
    else if (seq_cnt_q > SEQ_W'(MAX_SEQUENCES)) eff_cnt = SEQ_W'(MAX_SEQUENCES);
  end

  dvbf_pos u_pos (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .restart_i  (s_axis_tdata_i[0]),
    .seq_cnt_i  (eff_cnt),
    .adv_i      (adv),
    .valid_o    (pos_valid),
    .pos_o      (pos)
  );

  dvbf_enc u_enc (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (pos_valid),
    .pos_i           (pos),
    .pal_i           (pal_q),
    .adv_o           (adv),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// File: sv/dvbf_checker.sv
// Port-level checks of the DV black frame byte generator, bound to the top level.
module dvbf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // Position stays inside a block and a sequence
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[26:20] <= 7'd79) &&
                        (m_axis_tdata_o[19:12] <= 8'd149))
    else $error("position out of range");

  // Frame end only on the last byte of the last block, which is zero
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |->
      (m_axis_tdata_o[26:20] == 7'd79) && (m_axis_tdata_o[19:12] == 8'd149) &&
      (m_axis_tdata_o[7:0] == 8'h00))
    else $error("frame end flagged at wrong place");

  // First byte of every block is a type code
  a_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[26:20] == 7'd0) |->
      (m_axis_tdata_o[7:0] == 8'h1f) || (m_axis_tdata_o[7:0] == 8'h3f) ||
      (m_axis_tdata_o[7:0] == 8'h56) || (m_axis_tdata_o[7:0] == 8'h76) ||
      (m_axis_tdata_o[7:0] == 8'h96))
    else $error("bad block type code");

endmodule

bind dv_black_frame_byte_generator_top dvbf_checker u_dvbf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
